// ===== rtl/q2k_quantized_dot_product_top_defines.svh =====
// ----------------------------------------------------------------------------
// q2k assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef Q2K_QUANTIZED_DOT_PRODUCT_TOP_DEFINES_SVH
`define Q2K_QUANTIZED_DOT_PRODUCT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define Q2K_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("q2k assertion failed");
// next-cycle implication
`define Q2K_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("q2k assertion failed");
`else
`define Q2K_ASSERT_IMP(lbl, ante, cons)
`define Q2K_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/q2k_pkg.sv =====
// ----------------------------------------------------------------------------
// q2k_pkg
// shared types, constants and fp32 arithmetic helpers
// ----------------------------------------------------------------------------
package q2k_pkg;

   localparam int LANES = 4;
   localparam int LANE_IDX_W = $clog2(LANES);
   localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LANE,
      ST_ACC,
      ST_FOLD,
      ST_EMIT
   } q2k_state_type;

   typedef struct packed {
      logic                  acc_en;
      logic [LANE_IDX_W-1:0] lane_sel;
      logic                  fold;
      logic                  clear;
   } q2k_merge_ctrl_type;

   // normalize, handle underflow, round to nearest even and pack
   // e_top is the biased exponent if the leading one sits at bit 47
   function automatic logic [31:0] fp_round_pack(input logic s,
                                                 input logic signed [10:0] e_top,
                                                 input logic [47:0] p);
      logic [47:0] n;
      logic signed [10:0] ex;
      logic signed [10:0] dsh;
      logic [5:0] lz;
      logic [5:0] sh;
      logic found;
      logic st;
      logic [24:0] mr;
      logic [7:0] eo;
      logic [22:0] fr;
      logic [31:0] r;
      lz = '0;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found) begin
            if (p[i]) found = 1'b1;
            else lz = lz + 6'd1;
         end
      end
      n = p << lz;
      ex = e_top - $signed({5'b0, lz});
      if (ex < 11'sd1) begin
         dsh = 11'sd1 - ex;
         if (dsh > 11'sd47) begin
            st = |n;
            n = '0;
         end else begin
            sh = dsh[5:0];
            st = |(n & ((48'd1 << sh) - 48'd1));
            n = n >> sh;
         end
         n[0] = n[0] | st;
         ex = '0;
      end
      mr = {1'b0, n[47:24]} + {24'b0, (n[23] & ((|n[22:0]) | n[24]))};
      if (ex == 11'sd0) begin
         eo = mr[23] ? 8'd1 : 8'd0;
         fr = mr[22:0];
      end else if (mr[24]) begin
         ex = ex + 11'sd1;
         eo = ex[7:0];
         fr = mr[23:1];
      end else begin
         eo = ex[7:0];
         fr = mr[22:0];
      end
      if (ex > 11'sd254) r = {s, 8'hFF, 23'b0};
      else r = {s, eo, fr};
      if (p == '0) r = {s, 31'b0};
      return r;
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic s;
      logic [7:0] ea, eb;
      logic [23:0] ma, mb;
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [31:0] r;
      s = a[31] ^ b[31];
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
      a_zero = (a[30:0] == '0);
      b_zero = (b[30:0] == '0);
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {(a[30:23] != 8'd0), a[22:0]};
      mb = {(b[30:23] != 8'd0), b[22:0]};
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) r = FP_QNAN;
      else if (a_inf || b_inf) r = {s, 8'hFF, 23'b0};
      else if (a_zero || b_zero) r = {s, 31'b0};
      else r = fp_round_pack(s, $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126,
                             48'(ma) * 48'(mb));
      return r;
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] big, sml;
      logic a_nan, b_nan, a_inf, b_inf;
      logic [7:0] eA, eB, dexp;
      logic [26:0] mA, mB, mS;
      logic [27:0] sum;
      logic st;
      logic [31:0] r;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
      if (a[30:0] < b[30:0]) begin
         big = b;
         sml = a;
      end else begin
         big = a;
         sml = b;
      end
      eA = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eB = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      mA = {(big[30:23] != 8'd0), big[22:0], 3'b000};
      mB = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
      dexp = eA - eB;
      if (dexp > 8'd26) begin
         st = |mB;
         mS = '0;
      end else begin
         st = |(mB & ((27'd1 << dexp[4:0]) - 27'd1));
         mS = mB >> dexp[4:0];
      end
      mS[0] = mS[0] | st;
      if (big[31] == sml[31]) sum = {1'b0, mA} + {1'b0, mS};
      else sum = {1'b0, mA} - {1'b0, mS};
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) r = FP_QNAN;
      else if (a_inf) r = a;
      else if (b_inf) r = b;
      else if (sum == '0) r = {((big[31] == sml[31]) ? big[31] : 1'b0), 31'b0};
      else r = fp_round_pack(big[31], $signed({3'b0, eA}) + 11'sd1, {sum, 20'b0});
      return r;
   endfunction

   // exact fp16 to fp32 widening
   function automatic logic [31:0] fp_widen_half(input logic [15:0] h);
      logic [4:0] ex;
      logic [9:0] man;
      logic [3:0] lp;
      logic [32:0] t;
      logic [31:0] r;
      ex = h[14:10];
      man = h[9:0];
      lp = '0;
      for (int i = 0; i < 10; i++) begin
         if (man[i]) lp = 4'(i);
      end
      t = {23'b0, man} << (5'd23 - {1'b0, lp});
      if (ex == 5'd0) begin
         if (man == '0) r = {h[15], 31'b0};
         else r = {h[15], 8'd103 + {4'b0, lp}, t[22:0]};
      end else if (ex == 5'd31) begin
         r = {h[15], 8'hFF, man, 13'b0};
      end else begin
         r = {h[15], {3'b0, ex} + 8'd112, man, 13'b0};
      end
      return r;
   endfunction

   // small unsigned integer to fp32, exact
   function automatic logic [31:0] fp_from_nibble(input logic [3:0] v);
      logic [1:0] lp;
      logic [26:0] t;
      logic [31:0] r;
      lp = '0;
      for (int i = 0; i < 4; i++) begin
         if (v[i]) lp = 2'(i);
      end
      t = {23'b0, v} << (5'd23 - {3'b0, lp});
      if (v == '0) r = '0;
      else r = {1'b0, 8'd127 + {6'b0, lp}, t[22:0]};
      return r;
   endfunction

endpackage

// ===== rtl/q2k_if.sv =====
// ----------------------------------------------------------------------------
// q2k channel interfaces
// valid/ready channels for the request and response items
// ----------------------------------------------------------------------------
interface q2k_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  code_byte;
   logic [31:0] scale_bytes;
   logic [31:0] x_lane0;
   logic [31:0] x_lane1;
   logic [31:0] x_lane2;
   logic [31:0] x_lane3;
   logic [15:0] super_scale;
   logic [15:0] min_scale;
   logic [3:0]  lane_valid;
   logic        end_of_half;
   logic        end_of_row;

   modport source (
      output valid, code_byte, scale_bytes, x_lane0, x_lane1, x_lane2, x_lane3,
             super_scale, min_scale, lane_valid, end_of_half, end_of_row,
      input  ready
   );
   modport sink (
      input  valid, code_byte, scale_bytes, x_lane0, x_lane1, x_lane2, x_lane3,
             super_scale, min_scale, lane_valid, end_of_half, end_of_row,
      output ready
   );
endinterface

interface q2k_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] row_dot;

   modport source (output valid, row_dot, input ready);
   modport sink (input valid, row_dot, output ready);
endinterface

// ===== rtl/q2k_lane.sv =====
// ----------------------------------------------------------------------------
// q2k_lane
// one dequantize-and-multiply lane, four registered fp32 steps
// ----------------------------------------------------------------------------
module q2k_lane (
   input  logic        clock,
   input  logic [31:0] d,
   input  logic [31:0] dm,
   input  logic [1:0]  code,
   input  logic [7:0]  scale_byte,
   input  logic [31:0] x,
   output logic [31:0] term
);

   logic [31:0] a_ff, c_ff, b_ff, w_ff, t_ff;
   logic [31:0] a_in, c_in, b_in, w_in, t_in;

   always_comb begin
      a_in = q2k_pkg::fp_mul(d, q2k_pkg::fp_from_nibble(scale_byte[3:0]));
      c_in = q2k_pkg::fp_mul(dm, q2k_pkg::fp_from_nibble(scale_byte[7:4]));
      b_in = q2k_pkg::fp_mul(a_ff, q2k_pkg::fp_from_nibble({2'b00, code}));
      // b - c as b + (-c)
      w_in = q2k_pkg::fp_add(b_ff, {~c_ff[31], c_ff[30:0]});
      t_in = q2k_pkg::fp_mul(w_ff, x);
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      c_ff <= c_in;
      b_ff <= b_in;
      w_ff <= w_in;
      t_ff <= t_in;
   end

   assign term = t_ff;

endmodule

// ===== rtl/q2k_merge.sv =====
// ----------------------------------------------------------------------------
// q2k_merge
// lane-ordered half-block accumulation and row fold, one shared adder
// ----------------------------------------------------------------------------
module q2k_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  q2k_pkg::q2k_merge_ctrl_type   ctrl,
   input  logic [q2k_pkg::LANES-1:0]     lane_valid,
   input  logic [q2k_pkg::LANES-1:0][31:0] terms,
   output logic [31:0]                   row_sum
);

   logic [31:0] half_sum_ff, half_sum_in;
   logic [31:0] row_sum_ff, row_sum_in;
   logic [31:0] opa, opb, sum;

   always_comb begin
      opa = ctrl.fold ? row_sum_ff : half_sum_ff;
      opb = ctrl.fold ? half_sum_ff : terms[ctrl.lane_sel];
      sum = q2k_pkg::fp_add(opa, opb);
      half_sum_in = half_sum_ff;
      row_sum_in = row_sum_ff;
      if (ctrl.clear) begin
         half_sum_in = '0;
         row_sum_in = '0;
      end else if (ctrl.fold) begin
         row_sum_in = sum;
         half_sum_in = '0;
      end else if (ctrl.acc_en && lane_valid[ctrl.lane_sel]) begin
         half_sum_in = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_sum_ff <= '0;
         row_sum_ff <= '0;
      end else begin
         half_sum_ff <= half_sum_in;
         row_sum_ff <= row_sum_in;
      end
   end

   assign row_sum = row_sum_ff;

endmodule

// ===== rtl/q2k_quantized_dot_product_top.sv =====
// ----------------------------------------------------------------------------
// q2k_quantized_dot_product_top
// q2_k dequantize and dot product over a stream of packed weight bytes
// ----------------------------------------------------------------------------
// usage
//   req_port carries one item: a byte of four 2-bit codes, their four
//   scale/min bytes, four fp32 activations, fp16 d and dmin, a lane mask
//   and the half-block / row end flags. rsp_port carries one fp32 row dot
//   product for every item flagged end_of_row.
//   an item is taken when req_port.valid and req_port.ready are both high;
//   ready is high only while the sequencer is idle, one item in flight.
//   per item: the accept, the fill of the lane multiply pipeline, the shared
//   accumulator adding lanes 0..3 in order, a fold on a half or row end,
//   and on a row end the load of the result register. the serial adder in
//   the merge stage sets how fast items go through.
//   the result waits in an output register; a new item is taken while it
//   waits, and only a second row end stalls until the first result is read.
//   reset (synchronous, active high) clears the sums to +0.0 and drops
//   rsp_port.valid.
// ----------------------------------------------------------------------------
`include "q2k_quantized_dot_product_top_defines.svh"

module q2k_quantized_dot_product_top (
   input  logic           clock,
   input  logic           reset,
   q2k_req_if.sink        req_port,
   q2k_rsp_if.source      rsp_port
);

   // sequencer
   q2k_pkg::q2k_state_type state_ff, state_in;
   logic [q2k_pkg::LANE_IDX_W-1:0] cnt_ff, cnt_in;

   // captured item
   logic [7:0]  code_ff;
   logic [31:0] scale_ff;
   logic [q2k_pkg::LANES-1:0][31:0] x_ff;
   logic [31:0] d_ff, dm_ff;
   logic [q2k_pkg::LANES-1:0] valid_ff;
   logic eoh_ff, eor_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] row_dot_ff, row_dot_in;

   logic accept;
   logic out_free;
   q2k_pkg::q2k_merge_ctrl_type mctrl;
   logic [q2k_pkg::LANES-1:0][31:0] terms;
   logic [31:0] row_sum;

   assign accept = req_port.valid && req_port.ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == q2k_pkg::ST_IDLE);

   // capture item fields, widen the fp16 scales on the way in
   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff <= req_port.code_byte;
         scale_ff <= req_port.scale_bytes;
         x_ff[0] <= req_port.x_lane0;
         x_ff[1] <= req_port.x_lane1;
         x_ff[2] <= req_port.x_lane2;
         x_ff[3] <= req_port.x_lane3;
         d_ff <= q2k_pkg::fp_widen_half(req_port.super_scale);
         dm_ff <= q2k_pkg::fp_widen_half(req_port.min_scale);
         valid_ff <= req_port.lane_valid;
         eoh_ff <= req_port.end_of_half;
         eor_ff <= req_port.end_of_row;
      end
   end

   // parallel lanes, inputs held steady while the item is in flight
   for (genvar z = 0; z < q2k_pkg::LANES; z++) begin : g_lane
      q2k_lane u_lane (
         .clock      (clock),
         .d          (d_ff),
         .dm         (dm_ff),
         .code       (code_ff[2*z +: 2]),
         .scale_byte (scale_ff[8*z +: 8]),
         .x          (x_ff[z]),
         .term       (terms[z])
      );
   end

   q2k_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mctrl),
      .lane_valid (valid_ff),
      .terms      (terms),
      .row_sum    (row_sum)
   );

   // next state and merge control
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      mctrl = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      row_dot_in = row_dot_ff;
      case (state_ff)
         q2k_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = q2k_pkg::ST_LANE;
               cnt_in = '0;
            end
         end
         q2k_pkg::ST_LANE: begin
            // wait for the lane pipeline to fill
            cnt_in = cnt_ff + q2k_pkg::LANE_IDX_W'(1);
            if (cnt_ff == q2k_pkg::LANE_IDX_W'(q2k_pkg::LANES - 1)) begin
               state_in = q2k_pkg::ST_ACC;
            end
         end
         q2k_pkg::ST_ACC: begin
            // lanes added one per cycle, in lane order
            mctrl.acc_en = 1'b1;
            mctrl.lane_sel = cnt_ff;
            cnt_in = cnt_ff + q2k_pkg::LANE_IDX_W'(1);
            if (cnt_ff == q2k_pkg::LANE_IDX_W'(q2k_pkg::LANES - 1)) begin
               if (eoh_ff || eor_ff) state_in = q2k_pkg::ST_FOLD;
               else state_in = q2k_pkg::ST_IDLE;
            end
         end
         q2k_pkg::ST_FOLD: begin
            // row end also closes the pending half
            mctrl.fold = 1'b1;
            if (eor_ff) state_in = q2k_pkg::ST_EMIT;
            else state_in = q2k_pkg::ST_IDLE;
         end
         q2k_pkg::ST_EMIT: begin
            if (out_free) begin
               mctrl.clear = 1'b1;
               rsp_valid_in = 1'b1;
               // nan results leave as the canonical quiet nan
               if ((row_sum[30:23] == 8'hFF) && (row_sum[22:0] != '0)) begin
                  row_dot_in = q2k_pkg::FP_QNAN;
               end else begin
                  row_dot_in = row_sum;
               end
               state_in = q2k_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = q2k_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= q2k_pkg::ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_dot_ff <= row_dot_in;
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.row_dot = row_dot_ff;

   // an accepted item starts the lane fill from the first count
   `Q2K_ASSERT_NXT(a_accept_starts, accept,
      (state_ff == q2k_pkg::ST_LANE) && (cnt_ff == '0))
   // a fold happens only for items that close a half or a row
   `Q2K_ASSERT_IMP(a_fold_flag, state_ff == q2k_pkg::ST_FOLD, eoh_ff || eor_ff)
   // a row end with a free output register shows its result next cycle
   `Q2K_ASSERT_NXT(a_emit_shows, (state_ff == q2k_pkg::ST_EMIT) && out_free,
      rsp_valid_ff && (state_ff == q2k_pkg::ST_IDLE))

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q2k dot product testbench
// drives rows of packed 2-bit weight items with random gaps and stalls,
// predicts every fp32 row dot product bit for bit and checks each response
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [7:0]       code_byte;
   logic [31:0]      scale_bytes;
   logic [3:0][31:0] x_lane;
   logic [15:0]      super_scale;
   logic [15:0]      min_scale;
   logic [3:0]       lane_valid;
   logic             end_of_half;
   logic             end_of_row;
} dot_item_type;

class row_dot_scoreboard;
   logic [31:0] half_acc;
   logic [31:0] row_acc;
   logic [31:0] expected_dots[$];
   int          errors;

   function new();
      half_acc = '0;
      row_acc  = '0;
      errors   = 0;
   endfunction

   function automatic bit is_nan(logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != '0);
   endfunction

   function automatic bit is_inf(logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == '0);
   endfunction

   // round m * 2^e to fp32, nearest even, with gradual underflow
   function automatic logic [31:0] round_to_fp32(bit s, logic [127:0] m, int e);
      int p;
      int lsb_exp;
      int sh;
      int bexp;
      logic [127:0] mr;
      bit g;
      bit st;
      p = 0;
      for (int i = 0; i < 128; i++) if (m[i]) p = i;
      lsb_exp = p + e - 23;
      if (lsb_exp < -149) lsb_exp = -149;
      sh = lsb_exp - e;
      if (sh <= 0) begin
         mr = m << (-sh);
         g  = 0;
         st = 0;
      end else if (sh >= 128) begin
         mr = '0;
         g  = 0;
         st = |m;
      end else begin
         mr = m >> sh;
         g  = m[sh-1];
         st = |(m & ((128'd1 << (sh - 1)) - 128'd1));
      end
      if (g && (st || mr[0])) mr = mr + 128'd1;
      if (mr[24]) begin
         mr = mr >> 1;
         lsb_exp++;
      end
      if (mr == '0) return {s, 31'b0};
      if (!mr[23]) return {s, 8'h00, mr[22:0]};
      bexp = lsb_exp + 150;
      if (bexp >= 255) return {s, 8'hFF, 23'b0};
      return {s, bexp[7:0], mr[22:0]};
   endfunction

   function automatic void split_fp32(logic [31:0] a, output logic [127:0] m,
                                      output int e);
      if (a[30:23] == 8'd0) begin
         m = {105'b0, a[22:0]};
         e = -149;
      end else begin
         m = {104'b0, 1'b1, a[22:0]};
         e = int'(a[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      logic [127:0] ma, mb;
      int ea, eb;
      bit s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return 32'h7FC00000;
      if ((is_inf(a) && b[30:0] == '0) || (is_inf(b) && a[30:0] == '0))
         return 32'h7FC00000;
      if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'b0};
      if (a[30:0] == '0 || b[30:0] == '0) return {s, 31'b0};
      split_fp32(a, ma, ea);
      split_fp32(b, mb, eb);
      return round_to_fp32(s, ma * mb, ea + eb);
   endfunction

   function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      logic [127:0] ma, mb, tm, big_m, sml_m, total;
      int ea, eb, te, d, e_out;
      bit sa, sb, ts, s;
      if (is_nan(a) || is_nan(b)) return 32'h7FC00000;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return 32'h7FC00000;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'b0};
      if (a[30:0] == '0) return b;
      if (b[30:0] == '0) return a;
      split_fp32(a, ma, ea);
      split_fp32(b, mb, eb);
      sa = a[31];
      sb = b[31];
      if (ea < eb) begin
         tm = ma; ma = mb; mb = tm;
         te = ea; ea = eb; eb = te;
         ts = sa; sa = sb; sb = ts;
      end
      d = ea - eb;
      // far-apart operands: the small one only acts as a sticky bit
      if (d > 60) begin
         big_m = ma << 60;
         sml_m = 128'd1;
         e_out = ea - 60;
      end else begin
         big_m = ma << d;
         sml_m = mb;
         e_out = eb;
      end
      if (sa == sb) begin
         total = big_m + sml_m;
         s = sa;
      end else if (big_m >= sml_m) begin
         total = big_m - sml_m;
         s = sa;
      end else begin
         total = sml_m - big_m;
         s = sb;
      end
      if (total == '0) return 32'h0;
      return round_to_fp32(s, total, e_out);
   endfunction

   function automatic logic [31:0] half_to_fp32(logic [15:0] h);
      if (h[14:10] == 5'd0) begin
         if (h[9:0] == '0) return {h[15], 31'b0};
         return round_to_fp32(h[15], {118'b0, h[9:0]}, -24);
      end
      if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'b0};
      return {h[15], 3'b0 + h[14:10] + 8'd112, h[9:0], 13'b0};
   endfunction

   function automatic logic [31:0] small_to_fp32(logic [3:0] v);
      if (v == '0) return 32'h0;
      return round_to_fp32(1'b0, {124'b0, v}, 0);
   endfunction

   function void note_item(dot_item_type it);
      logic [31:0] d, dm, a, b, c, w, t;
      logic [7:0] sbyte;
      d  = half_to_fp32(it.super_scale);
      dm = half_to_fp32(it.min_scale);
      for (int z = 0; z < 4; z++) begin
         if (it.lane_valid[z]) begin
            sbyte = it.scale_bytes[8*z +: 8];
            a = fmul(d, small_to_fp32(sbyte[3:0]));
            b = fmul(a, small_to_fp32({2'b0, it.code_byte[2*z +: 2]}));
            c = fmul(dm, small_to_fp32(sbyte[7:4]));
            w = fadd(b, {~c[31], c[30:0]});
            t = fmul(w, it.x_lane[z]);
            half_acc = fadd(half_acc, t);
         end
      end
      if (it.end_of_half || it.end_of_row) begin
         row_acc  = fadd(row_acc, half_acc);
         half_acc = '0;
      end
      if (it.end_of_row) begin
         expected_dots.push_back(is_nan(row_acc) ? 32'h7FC00000 : row_acc);
         row_acc = '0;
      end
   endfunction

   function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (expected_dots.size() == 0) begin
         $error("row_dot: unexpected result %h", got);
         errors++;
      end else begin
         want = expected_dots.pop_front();
         if (want !== got) begin
            $error("row_dot mismatch: expected %h, actual %h", want, got);
            errors++;
         end
      end
   endfunction

   function int pending();
      return expected_dots.size();
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;
   int   cycle_count;
   int   items_sent;
   bit   quiet;       // no idling on either side near the end
   bit   hold_rsp;    // asks the receiver for one long hold-off

   q2k_req_if req ();
   q2k_rsp_if rsp ();

   row_dot_scoreboard sb = new();

   q2k_quantized_dot_product_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req.sink),
      .rsp_port (rsp.source)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // every accepted request item goes into the prediction
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         sb.note_item({req.code_byte, req.scale_bytes,
                       {req.x_lane3, req.x_lane2, req.x_lane1, req.x_lane0},
                       req.super_scale, req.min_scale, req.lane_valid,
                       req.end_of_half, req.end_of_row});
      end
   end

   // every accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_result(rsp.row_dot);
   end

   // response side: random stall bursts, one long hold-off on request
   initial begin
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            // long hold-off so that a finished row sits and the block stops
            // taking items
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // offer one item and hold it until the handshake, then maybe idle
   task automatic push_item(input dot_item_type it);
      req.valid       <= 1'b1;
      req.code_byte   <= it.code_byte;
      req.scale_bytes <= it.scale_bytes;
      req.x_lane0     <= it.x_lane[0];
      req.x_lane1     <= it.x_lane[1];
      req.x_lane2     <= it.x_lane[2];
      req.x_lane3     <= it.x_lane[3];
      req.super_scale <= it.super_scale;
      req.min_scale   <= it.min_scale;
      req.lane_valid  <= it.lane_valid;
      req.end_of_half <= it.end_of_half;
      req.end_of_row  <= it.end_of_row;
      do @(posedge clock); while (!req.ready);
      items_sent++;
      // idle bursts, with stretches of back-to-back items in between
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   function automatic dot_item_type make_item(logic [7:0] codes, logic [31:0] scales,
                                              logic [31:0] x0, logic [31:0] x1,
                                              logic [31:0] x2, logic [31:0] x3,
                                              logic [15:0] d, logic [15:0] dm,
                                              logic [3:0] lanes, bit eoh, bit eor);
      dot_item_type it;
      it.code_byte   = codes;
      it.scale_bytes = scales;
      it.x_lane      = {x3, x2, x1, x0};
      it.super_scale = d;
      it.min_scale   = dm;
      it.lane_valid  = lanes;
      it.end_of_half = eoh;
      it.end_of_row  = eor;
      return it;
   endfunction

   // activations: mostly moderate magnitudes, some raw bit patterns and specials
   function automatic logic [31:0] pick_activation();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 75) return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
      if (sel < 90) return $urandom;
      if (sel < 94) return {1'($urandom), 31'h0};
      if (sel < 96) return {1'($urandom), 8'h00, 23'($urandom)};
      if (sel < 98) return {1'($urandom), 8'hFF, 23'h0};
      return {1'($urandom), 8'hFF, 23'($urandom) | 23'h1};
   endfunction

   // fp16 scales: mostly normal small values, sometimes any pattern
   function automatic logic [15:0] pick_half();
      if ($urandom_range(0, 99) < 85)
         return {1'($urandom), 5'($urandom_range(6, 20)), 10'($urandom)};
      return 16'($urandom);
   endfunction

   // one row: runs of full items, a half end every 32 items and at random, ragged tail
   task automatic send_row(input int len);
      logic [15:0] d, dm;
      dot_item_type it;
      bit eoh;
      logic [3:0] lanes;
      d  = pick_half();
      dm = pick_half();
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) d = pick_half();
         if ($urandom_range(0, 9) == 0) dm = pick_half();
         eoh = ((i + 1) % 32 == 0) || ($urandom_range(0, 19) == 0);
         lanes = 4'hF;
         if (i == len - 1) lanes = 4'($urandom);
         else if ($urandom_range(0, 19) == 0) lanes = 4'($urandom);
         it = make_item(8'($urandom), $urandom, pick_activation(), pick_activation(),
                        pick_activation(), pick_activation(), d, dm, lanes, eoh,
                        i == len - 1);
         push_item(it);
      end
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int row_len;
      bit hold_done;
      bit drain_done;
      cycle_count = 0;
      items_sent  = 0;
      quiet       = 1'b0;
      hold_rsp    = 1'b0;
      hold_done   = 1'b0;
      drain_done  = 1'b0;
      reset       = 1'b1;
      req.valid       = 1'b0;
      req.code_byte   = '0;
      req.scale_bytes = '0;
      req.x_lane0     = '0;
      req.x_lane1     = '0;
      req.x_lane2     = '0;
      req.x_lane3     = '0;
      req.super_scale = '0;
      req.min_scale   = '0;
      req.lane_valid  = '0;
      req.end_of_half = 1'b0;
      req.end_of_row  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all zero row
      push_item(make_item(8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                          16'h0000, 16'h0000, 4'hF, 1'b0, 1'b1));
      // largest codes and nibbles, unit scales and activations
      push_item(make_item(8'hFF, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h3F80_0000,
                          32'h3F80_0000, 32'h3F80_0000, 16'h3C00, 16'h3C00,
                          4'hF, 1'b0, 1'b1));
      // invalid lanes add nothing, even with a NaN in them
      push_item(make_item(8'hE4, 32'h1234_5678, 32'h7FC0_0001, 32'hBF80_0000,
                          32'hFF80_0000, 32'h4000_0000, 16'h3C00, 16'hBC00,
                          4'b1010, 1'b0, 1'b0));
      push_item(make_item(8'h1B, 32'h8765_4321, 32'h4040_0000, 32'h7F80_0000,
                          32'h0000_0001, 32'h8000_0000, 16'h4000, 16'h3800,
                          4'h0, 1'b0, 1'b1));
      // half end mid-row, then row end without a half end
      push_item(make_item(8'h93, 32'h5A5A_A5A5, 32'h4120_0000, 32'hC0A0_0000,
                          32'h3E80_0000, 32'h4480_0000, 16'h3555, 16'h2E66,
                          4'hF, 1'b1, 1'b0));
      push_item(make_item(8'h6C, 32'hF00F_0FF0, 32'hC2C8_0000, 32'h3DCC_CCCD,
                          32'h4B00_0001, 32'h3380_0000, 16'h3555, 16'h2E66,
                          4'hF, 1'b0, 1'b0));
      push_item(make_item(8'h27, 32'h0F0F_F0F0, 32'h3F00_0000, 32'hBF00_0000,
                          32'h4100_0000, 32'hC100_0000, 16'h3555, 16'h2E66,
                          4'b0111, 1'b0, 1'b1));
      // NaN activation gives the canonical NaN
      push_item(make_item(8'h55, 32'h1111_1111, 32'hFFFF_FFFF, 32'h3F80_0000,
                          32'h3F80_0000, 32'h3F80_0000, 16'h3C00, 16'h3C00,
                          4'hF, 1'b0, 1'b1));
      // infinite scale against zero nibble, and infinite min
      push_item(make_item(8'hAA, 32'h0000_0001, 32'h3F80_0000, 32'h3F80_0000,
                          32'h3F80_0000, 32'h3F80_0000, 16'h7C00, 16'h3C00,
                          4'hF, 1'b0, 1'b1));
      push_item(make_item(8'hFF, 32'h1010_1010, 32'h3F80_0000, 32'h3F80_0000,
                          32'h3F80_0000, 32'h3F80_0000, 16'h3C00, 16'hFC00,
                          4'hF, 1'b0, 1'b1));
      // fp16 subnormal and NaN scales
      push_item(make_item(8'hFF, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h0080_0000,
                          32'h0000_0001, 32'hFF7F_FFFF, 16'h0001, 16'h83FF,
                          4'hF, 1'b0, 1'b1));
      push_item(make_item(8'h0F, 32'h3C3C_C3C3, 32'h3F80_0000, 32'h3F80_0000,
                          32'h3F80_0000, 32'h3F80_0000, 16'h7E01, 16'h0000,
                          4'hF, 1'b0, 1'b1));
      // overflow to infinity, then a cancelling row
      push_item(make_item(8'hFF, 32'h0F0F_0F0F, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                          32'h7F7F_FFFF, 32'h7F7F_FFFF, 16'h7BFF, 16'h0000,
                          4'hF, 1'b1, 1'b0));
      push_item(make_item(8'hFF, 32'h0F0F_0F0F, 32'hFF7F_FFFF, 32'hFF7F_FFFF,
                          32'hFF7F_FFFF, 32'hFF7F_FFFF, 16'h7BFF, 16'h0000,
                          4'hF, 1'b1, 1'b1));
      push_item(make_item(8'h00, 32'hF0F0_F0F0, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 16'h3C00, 16'hFBFF,
                          4'hF, 1'b0, 1'b1));

      // random rows; single-item rows while the response side is held off
      // fill the block, then the sender drains once
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 150 && !hold_done) begin
            hold_done = 1'b1;
            hold_rsp = 1'b1;
            for (int k = 0; k < 6; k++) send_row(1);
         end
         if (items_sent >= 300 && !drain_done) begin
            drain_done = 1'b1;
            req.valid <= 1'b0;
            wait_drained();
            @(posedge clock);
         end
         if (items_sent >= RANDOM_ITEMS - 60) quiet = 1'b1;
         row_len = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 70)
                                                : $urandom_range(1, 12);
         send_row(row_len);
      end
      req.valid <= 1'b0;

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
